// ----- rtl/core/cpu8_pkg.sv -----
// Package for the 8-bit execute core: mnemonic codes, status bit positions, reset values, stack page.
// No dependencies.
package cpu8_pkg;

  typedef enum logic [5:0] {
    K_ADC = 6'd0,  K_AND = 6'd1,  K_ASL = 6'd2,  K_BCC = 6'd3,  K_BCS = 6'd4,
    K_BEQ = 6'd5,  K_BIT = 6'd6,  K_BMI = 6'd7,  K_BNE = 6'd8,  K_BPL = 6'd9,
    K_BRK = 6'd10, K_BVC = 6'd11, K_BVS = 6'd12, K_CLC = 6'd13, K_CLD = 6'd14,
    K_CLI = 6'd15, K_CLV = 6'd16, K_CMP = 6'd17, K_CPX = 6'd18, K_CPY = 6'd19,
    K_DEC = 6'd20, K_DEX = 6'd21, K_DEY = 6'd22, K_EOR = 6'd23, K_INC = 6'd24,
    K_INX = 6'd25, K_INY = 6'd26, K_JMP = 6'd27, K_JSR = 6'd28, K_LDA = 6'd29,
    K_LDX = 6'd30, K_LDY = 6'd31, K_LSR = 6'd32, K_NOP = 6'd33, K_ORA = 6'd34,
    K_PHA = 6'd35, K_PHP = 6'd36, K_PLA = 6'd37, K_PLP = 6'd38, K_ROL = 6'd39,
    K_ROR = 6'd40, K_RTI = 6'd41, K_RTS = 6'd42, K_SBC = 6'd43, K_SEC = 6'd44,
    K_SED = 6'd45, K_SEI = 6'd46, K_STA = 6'd47, K_STX = 6'd48, K_STY = 6'd49,
    K_TAX = 6'd50, K_TAY = 6'd51, K_TSX = 6'd52, K_TXA = 6'd53, K_TXS = 6'd54,
    K_TYA = 6'd55
  } kind_t;

  localparam int unsigned FC = 0;
  localparam int unsigned FZ = 1;
  localparam int unsigned FI = 2;
  localparam int unsigned FD = 3;
  localparam int unsigned FB = 4;
  localparam int unsigned FU = 5;
  localparam int unsigned FV = 6;
  localparam int unsigned FN = 7;

  localparam logic [7:0]  SP_RESET    = 8'hFD;
  localparam logic [7:0]  FLAGS_RESET = 8'h20;
  localparam logic [7:0]  STACK_PAGE  = 8'h01;

endpackage

// ----- rtl/core/cpu8bit_instruction_execute_core.sv -----
// Execute stage of the 8-bit accumulator processor (top level).
// Depends on cpu8_pkg.
//
// One decoded instruction per s_axis beat; each gives one to three result
// beats on m_axis (one per memory write, or one without a write). Register
// file A/X/Y/SP/P updates in the accept cycle, so the next instruction may
// follow immediately: while m_axis_tready is high, m_axis carries one beat
// per cycle, and an instruction with n writes gives n beats (BRK three, JSR
// two). The result buffer holds all writes of one instruction; a new
// instruction is taken while its last beat is leaving. Results show on
// m_axis from the cycle after acceptance. ADC/SBC are binary only.
module cpu8bit_instruction_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[5:0] opcode[13:6] operand[21:14] accumulator_mode[22]
  // effective_address[38:23] branch_offset[54:39] current_pc[70:55]
  // pull_first[78:71] pull_second[86:79] pull_third[94:87]
  // break_vector[110:95], zero to 112
  input  logic [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // write_valid[0] write_address[16:1] write_data[24:17] acc_value[32:25]
  // x_value[40:33] y_value[48:41] sp_value[56:49] flags_value[64:57]
  // next_pc[80:65] extra_cycles[82:81] may_add_cycle[83], zero to 88
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast       // final_item
);
  import cpu8_pkg::*;

  logic [5:0]  kind;
  logic [7:0]  opcode, m, p1, p2, p3;
  logic        acc_mode;
  logic [15:0] ea, rel, pc_in, vec;
  assign kind     = s_axis_tdata[5:0];
  assign opcode   = s_axis_tdata[13:6];
  assign m        = s_axis_tdata[21:14];
  assign acc_mode = s_axis_tdata[22];
  assign ea       = s_axis_tdata[38:23];
  assign rel      = s_axis_tdata[54:39];
  assign pc_in    = s_axis_tdata[70:55];
  assign p1       = s_axis_tdata[78:71];
  assign p2       = s_axis_tdata[86:79];
  assign p3       = s_axis_tdata[94:87];
  assign vec      = s_axis_tdata[110:95];

  // architectural state
  logic [7:0] a, x, y, sp, p;
  logic [7:0] a_next, x_next, y_next, sp_next, p_next;

  // result buffer: shared register snapshot plus up to three writes
  logic [15:0] wa [3];
  logic [7:0]  wd [3];
  logic [1:0]  wcnt;      // writes held
  logic [1:0]  idx;       // beat being shown
  logic        busy;
  logic [15:0] pc_out;
  logic [1:0]  extra_out;
  logic        may_out;
  logic [7:0]  a_o, x_o, y_o, sp_o, p_o;

  logic [15:0] wa_n [3];
  logic [7:0]  wd_n [3];
  logic [1:0]  wcnt_next;
  logic [15:0] pc_next;
  logic [1:0]  extra_next;
  logic        may_next;

  logic last_beat, accept;
  assign last_beat     = (wcnt == 2'd0) || (idx == wcnt - 2'd1);
  assign s_axis_tready = !busy || (m_axis_tready && last_beat);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [8:0]  t;
    logic [7:0]  r, v, d;
    logic [15:0] pcp, tgt;
    logic        br, take, cin;
    a_next = a; x_next = x; y_next = y; sp_next = sp; p_next = p;
    wcnt_next = 2'd0;
    for (int i = 0; i < 3; i++) begin
      wa_n[i] = '0;
      wd_n[i] = '0;
    end
    pc_next = pc_in; extra_next = 2'd0; may_next = 1'b0;
    cin = p[FC]; br = 1'b0; take = 1'b0;
    t = '0; r = '0; v = '0; d = '0;
    pcp = 16'(pc_in + 16'd1);
    case (kind)
      K_ADC, K_SBC: begin
        v = (kind == K_SBC) ? ~m : m;
        t = {1'b0, a} + {1'b0, v} + {8'd0, cin};
        p_next[FC] = t[8];
        p_next[FV] = ~(a[7] ^ v[7]) & (a[7] ^ t[7]);
        a_next = t[7:0];
        may_next = 1'b1;
      end
      K_AND: begin a_next = a & m; may_next = 1'b1; end
      K_EOR: begin a_next = a ^ m; may_next = 1'b1; end
      K_ORA: begin a_next = a | m; may_next = 1'b1; end
      K_LDA: begin a_next = m; may_next = 1'b1; end
      K_LDX: begin x_next = m; may_next = 1'b1; end
      K_LDY: begin y_next = m; may_next = 1'b1; end
      K_ASL, K_LSR, K_ROL, K_ROR: begin
        case (kind)
          K_ASL:   begin p_next[FC] = m[7]; r = {m[6:0], 1'b0}; end
          K_LSR:   begin p_next[FC] = m[0]; r = {1'b0, m[7:1]}; end
          K_ROL:   begin p_next[FC] = m[7]; r = {m[6:0], cin}; end
          default: begin p_next[FC] = m[0]; r = {cin, m[7:1]}; end
        endcase
        if (acc_mode) a_next = r;
        else begin wcnt_next = 2'd1; wa_n[0] = ea; wd_n[0] = r; end
      end
      K_BCC: begin br = 1'b1; take = !p[FC]; end
      K_BCS: begin br = 1'b1; take = p[FC]; end
      K_BEQ: begin br = 1'b1; take = p[FZ]; end
      K_BNE: begin br = 1'b1; take = !p[FZ]; end
      K_BMI: begin br = 1'b1; take = p[FN]; end
      K_BPL: begin br = 1'b1; take = !p[FN]; end
      K_BVC: begin br = 1'b1; take = !p[FV]; end
      K_BVS: begin br = 1'b1; take = p[FV]; end
      K_BIT: begin
        p_next[FZ] = (a & m) == 8'd0;
        p_next[FN] = m[7];
        p_next[FV] = m[6];
      end
      K_BRK: begin
        wcnt_next = 2'd3;
        wa_n[0] = {STACK_PAGE, sp};
        wd_n[0] = pcp[15:8];
        wa_n[1] = {STACK_PAGE, 8'(sp - 8'd1)};
        wd_n[1] = pcp[7:0];
        wa_n[2] = {STACK_PAGE, 8'(sp - 8'd2)};
        wd_n[2] = p | 8'h30;
        sp_next = 8'(sp - 8'd3);
        p_next = (p | 8'h24) & 8'hEF;
        pc_next = vec;
      end
      K_CLC: p_next[FC] = 1'b0;
      K_CLD: p_next[FD] = 1'b0;
      K_CLI: p_next[FI] = 1'b0;
      K_CLV: p_next[FV] = 1'b0;
      K_SEC: p_next[FC] = 1'b1;
      K_SED: p_next[FD] = 1'b1;
      K_SEI: p_next[FI] = 1'b1;
      K_CMP, K_CPX, K_CPY: begin
        r = (kind == K_CMP) ? a : ((kind == K_CPX) ? x : y);
        d = 8'(r - m);
        p_next[FC] = r >= m;
        p_next[FZ] = d == 8'd0;
        p_next[FN] = d[7];
        may_next = (kind == K_CMP);
      end
      K_DEC, K_INC: begin
        r = (kind == K_DEC) ? 8'(m - 8'd1) : 8'(m + 8'd1);
        wcnt_next = 2'd1; wa_n[0] = ea; wd_n[0] = r;
      end
      K_DEX: x_next = 8'(x - 8'd1);
      K_DEY: y_next = 8'(y - 8'd1);
      K_INX: x_next = 8'(x + 8'd1);
      K_INY: y_next = 8'(y + 8'd1);
      K_JMP: pc_next = ea;
      K_JSR: begin
        tgt = 16'(pc_in - 16'd1);
        wcnt_next = 2'd2;
        wa_n[0] = {STACK_PAGE, sp};
        wd_n[0] = tgt[15:8];
        wa_n[1] = {STACK_PAGE, 8'(sp - 8'd1)};
        wd_n[1] = tgt[7:0];
        sp_next = 8'(sp - 8'd2);
        pc_next = ea;
      end
      K_NOP: may_next = (opcode == 8'h1C) || (opcode == 8'h3C) || (opcode == 8'h5C)
                     || (opcode == 8'h7C) || (opcode == 8'hDC) || (opcode == 8'hFC);
      K_PHA, K_PHP: begin
        wcnt_next = 2'd1;
        wa_n[0] = {STACK_PAGE, sp};
        wd_n[0] = (kind == K_PHA) ? a : (p | 8'h30);
        sp_next = 8'(sp - 8'd1);
      end
      K_PLA: begin sp_next = 8'(sp + 8'd1); a_next = p1; end
      K_PLP: begin sp_next = 8'(sp + 8'd1); p_next = (p1 & 8'hEF) | 8'h20; end
      K_RTI: begin
        sp_next = 8'(sp + 8'd3);
        p_next = p1 & 8'hCF;
        pc_next = {p3, p2};
      end
      K_RTS: begin sp_next = 8'(sp + 8'd2); pc_next = 16'({p2, p1} + 16'd1); end
      K_STA: begin wcnt_next = 2'd1; wa_n[0] = ea; wd_n[0] = a; end
      K_STX: begin wcnt_next = 2'd1; wa_n[0] = ea; wd_n[0] = x; end
      K_STY: begin wcnt_next = 2'd1; wa_n[0] = ea; wd_n[0] = y; end
      K_TAX: x_next = a;
      K_TAY: y_next = a;
      K_TSX: x_next = sp;
      K_TXA: a_next = x;
      K_TXS: sp_next = x;
      K_TYA: a_next = y;
      default: ;
    endcase
    // N/Z from the byte that the instruction produced
    case (kind)
      K_ADC, K_SBC, K_AND, K_EOR, K_ORA, K_LDA, K_PLA, K_TXA, K_TYA: begin
        p_next[FZ] = a_next == 8'd0; p_next[FN] = a_next[7];
      end
      K_LDX, K_DEX, K_INX, K_TAX, K_TSX: begin
        p_next[FZ] = x_next == 8'd0; p_next[FN] = x_next[7];
      end
      K_LDY, K_DEY, K_INY, K_TAY: begin
        p_next[FZ] = y_next == 8'd0; p_next[FN] = y_next[7];
      end
      K_ASL, K_LSR, K_ROL, K_ROR, K_DEC, K_INC: begin
        p_next[FZ] = r == 8'd0; p_next[FN] = r[7];
      end
      default: ;
    endcase
    if (br && take) begin
      tgt = 16'(pc_in + rel);
      pc_next = tgt;
      extra_next = (tgt[15:8] != pc_in[15:8]) ? 2'd2 : 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0; x <= '0; y <= '0; sp <= SP_RESET; p <= FLAGS_RESET;
      busy <= 1'b0; idx <= '0; wcnt <= '0;
    end else begin
      if (accept) begin
        a <= a_next; x <= x_next; y <= y_next; sp <= sp_next; p <= p_next;
        busy <= 1'b1; idx <= '0; wcnt <= wcnt_next;
      end else if (busy && m_axis_tready) begin
        if (last_beat) busy <= 1'b0;
        else idx <= idx + 2'd1;
      end
    end
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        wa[i] <= wa_n[i];
        wd[i] <= wd_n[i];
      end
      a_o <= a_next; x_o <= x_next; y_o <= y_next; sp_o <= sp_next; p_o <= p_next;
      pc_out <= pc_next; extra_out <= extra_next; may_out <= may_next;
    end
  end

  logic        wv;
  logic [15:0] wa_sel;
  logic [7:0]  wd_sel;
  always_comb begin
    wv = wcnt != 2'd0;
    case (idx)
      2'd0:    begin wa_sel = wa[0]; wd_sel = wd[0]; end
      2'd1:    begin wa_sel = wa[1]; wd_sel = wd[1]; end
      default: begin wa_sel = wa[2]; wd_sel = wd[2]; end
    endcase
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = last_beat;
  assign m_axis_tdata  = {4'd0, may_out, extra_out, pc_out, p_o, sp_o, y_o, x_o, a_o,
                          wd_sel, wa_sel, wv};
endmodule

// ----- dv/cpu8bit_instruction_execute_core_test.sv -----
// Testbench for the 8-bit execute core: directed and random instruction beats
// checked against an in-bench register model. Depends on cpu8_pkg and the core.
module cpu8bit_instruction_execute_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cpu8_pkg::*;

  typedef struct packed {
    logic [15:0] vec;
    logic [7:0]  p3, p2, p1;
    logic [15:0] pc, rel, ea;
    logic        accm;
    logic [7:0]  m, opc;
    logic [5:0]  kind;
  } instr_t;

  typedef struct packed {
    logic        may;
    logic [1:0]  extra;
    logic [15:0] npc;
    logic [7:0]  p, sp, y, x, a, wdata;
    logic [15:0] waddr;
    logic        wv;
  } res_t;

  localparam logic [5:0] K_ILLEGAL = 6'd56;
  localparam int unsigned STALL_LIMIT = 2000;

  class exec_scoreboard;
    logic [7:0] a, x, y, sp, p;
    res_t pending[$];
    logic pending_last[$];
    int errors;

    function new();
      a = '0; x = '0; y = '0; sp = SP_RESET; p = FLAGS_RESET; errors = 0;
    endfunction

    function void nz(logic [7:0] v);
      p[FZ] = (v == 8'd0); p[FN] = v[7];
    endfunction

    // Apply one instruction to the register copy and queue its results.
    function void note_instr(instr_t i);
      logic [15:0] wa[3];
      logic [7:0] wd[3];
      int nw, n;
      logic [15:0] pc, tgt;
      logic [8:0] t;
      logic [7:0] r, v;
      logic cin, may, br;
      logic [1:0] extra;
      res_t o;
      nw = 0; pc = i.pc; cin = p[FC]; may = 1'b0; br = 1'b0; extra = 2'd0;
      case (i.kind)
        K_ADC, K_SBC: begin
          v = (i.kind == K_SBC) ? ~i.m : i.m;
          t = {1'b0, a} + {1'b0, v} + {8'd0, cin};
          p[FC] = t[8];
          p[FV] = (~(a ^ v) & (a ^ t[7:0]) & 8'h80) != 8'd0;
          a = t[7:0]; nz(a); may = 1'b1;
        end
        K_AND: begin a = a & i.m; nz(a); may = 1'b1; end
        K_EOR: begin a = a ^ i.m; nz(a); may = 1'b1; end
        K_ORA: begin a = a | i.m; nz(a); may = 1'b1; end
        K_ASL, K_LSR, K_ROL, K_ROR: begin
          case (i.kind)
            K_ASL: begin p[FC] = i.m[7]; r = {i.m[6:0], 1'b0}; end
            K_LSR: begin p[FC] = i.m[0]; r = {1'b0, i.m[7:1]}; end
            K_ROL: begin p[FC] = i.m[7]; r = {i.m[6:0], cin}; end
            default: begin p[FC] = i.m[0]; r = {cin, i.m[7:1]}; end
          endcase
          nz(r);
          if (i.accm) a = r;
          else begin wa[nw] = i.ea; wd[nw] = r; nw++; end
        end
        K_BCC: br = !cin;
        K_BCS: br = cin;
        K_BEQ: br = p[FZ];
        K_BNE: br = !p[FZ];
        K_BMI: br = p[FN];
        K_BPL: br = !p[FN];
        K_BVC: br = !p[FV];
        K_BVS: br = p[FV];
        K_BIT: begin
          p[FZ] = (a & i.m) == 8'd0; p[FN] = i.m[7]; p[FV] = i.m[6];
        end
        K_BRK: begin
          pc = pc + 16'd1;
          wa[0] = {STACK_PAGE, sp}; wd[0] = pc[15:8]; sp--;
          wa[1] = {STACK_PAGE, sp}; wd[1] = pc[7:0]; sp--;
          p[FB] = 1'b1; p[FU] = 1'b1;
          wa[2] = {STACK_PAGE, sp}; wd[2] = p; sp--;
          nw = 3; p[FB] = 1'b0; p[FI] = 1'b1; pc = i.vec;
        end
        K_CLC: p[FC] = 1'b0;
        K_CLD: p[FD] = 1'b0;
        K_CLI: p[FI] = 1'b0;
        K_CLV: p[FV] = 1'b0;
        K_CMP, K_CPX, K_CPY: begin
          v = (i.kind == K_CMP) ? a : (i.kind == K_CPX) ? x : y;
          p[FC] = v >= i.m; nz(8'(v - i.m)); may = (i.kind == K_CMP);
        end
        K_DEC, K_INC: begin
          r = (i.kind == K_DEC) ? 8'(i.m - 8'd1) : 8'(i.m + 8'd1);
          wa[0] = i.ea; wd[0] = r; nw = 1; nz(r);
        end
        K_DEX: begin x--; nz(x); end
        K_DEY: begin y--; nz(y); end
        K_INX: begin x++; nz(x); end
        K_INY: begin y++; nz(y); end
        K_JMP: pc = i.ea;
        K_JSR: begin
          pc = pc - 16'd1;
          wa[0] = {STACK_PAGE, sp}; wd[0] = pc[15:8]; sp--;
          wa[1] = {STACK_PAGE, sp}; wd[1] = pc[7:0]; sp--;
          nw = 2; pc = i.ea;
        end
        K_LDA: begin a = i.m; nz(a); may = 1'b1; end
        K_LDX: begin x = i.m; nz(x); may = 1'b1; end
        K_LDY: begin y = i.m; nz(y); may = 1'b1; end
        K_NOP: may = i.opc inside {8'h1C, 8'h3C, 8'h5C, 8'h7C, 8'hDC, 8'hFC};
        K_PHA: begin wa[0] = {STACK_PAGE, sp}; wd[0] = a; nw = 1; sp--; end
        K_PHP: begin
          wa[0] = {STACK_PAGE, sp}; wd[0] = p | 8'h30; nw = 1; sp--;
        end
        K_PLA: begin sp++; a = i.p1; nz(a); end
        K_PLP: begin sp++; p = (i.p1 & ~8'h10) | 8'h20; end
        K_RTI: begin sp = sp + 8'd3; p = i.p1 & ~8'h30; pc = {i.p3, i.p2}; end
        K_RTS: begin sp = sp + 8'd2; pc = {i.p2, i.p1} + 16'd1; end
        K_SEC: p[FC] = 1'b1;
        K_SED: p[FD] = 1'b1;
        K_SEI: p[FI] = 1'b1;
        K_STA: begin wa[0] = i.ea; wd[0] = a; nw = 1; end
        K_STX: begin wa[0] = i.ea; wd[0] = x; nw = 1; end
        K_STY: begin wa[0] = i.ea; wd[0] = y; nw = 1; end
        K_TAX: begin x = a; nz(x); end
        K_TAY: begin y = a; nz(y); end
        K_TSX: begin x = sp; nz(x); end
        K_TXA: begin a = x; nz(a); end
        K_TXS: sp = x;
        K_TYA: begin a = y; nz(a); end
        default: ;
      endcase
      if (br) begin
        tgt = pc + i.rel;
        extra = (tgt[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
        pc = tgt;
      end
      n = (nw > 0) ? nw : 1;
      for (int k = 0; k < n; k++) begin
        o = '0;
        if (k < nw) begin o.wv = 1'b1; o.waddr = wa[k]; o.wdata = wd[k]; end
        o.a = a; o.x = x; o.y = y; o.sp = sp; o.p = p;
        o.npc = pc; o.extra = extra; o.may = may;
        pending.push_back(o);
        pending_last.push_back(k == n - 1);
      end
    endfunction

    function void check_result(res_t got, logic last);
      res_t e;
      logic el;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      el = pending_last.pop_front();
      if (got.wv !== e.wv) cmp("write_valid", 16'(e.wv), 16'(got.wv));
      if (got.waddr !== e.waddr) cmp("write_address", e.waddr, got.waddr);
      if (got.wdata !== e.wdata) cmp("write_data", 16'(e.wdata), 16'(got.wdata));
      if (got.a !== e.a) cmp("acc_value", 16'(e.a), 16'(got.a));
      if (got.x !== e.x) cmp("x_value", 16'(e.x), 16'(got.x));
      if (got.y !== e.y) cmp("y_value", 16'(e.y), 16'(got.y));
      if (got.sp !== e.sp) cmp("sp_value", 16'(e.sp), 16'(got.sp));
      if (got.p !== e.p) cmp("flags_value", 16'(e.p), 16'(got.p));
      if (got.npc !== e.npc) cmp("next_pc", e.npc, got.npc);
      if (got.extra !== e.extra) cmp("extra_cycles", 16'(e.extra), 16'(got.extra));
      if (got.may !== e.may) cmp("may_add_cycle", 16'(e.may), 16'(got.may));
      if (last !== el) cmp("final_item", 16'(el), 16'(last));
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [111:0] s_axis_tdata;   // instr_t packed, kind in the lowest bits
  logic m_axis_tvalid, m_axis_tready;
  logic [87:0] m_axis_tdata;    // res_t packed, write_valid in bit 0
  logic m_axis_tlast;

  cpu8bit_instruction_execute_core uut (.*);

  exec_scoreboard sb;
  bit quiet;          // no idling on either side in the closing stretch
  int unsigned stall_count, n_sent, n_results;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: random back-pressure bursts, checking on the rising edge.
  initial begin
    int burst;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        m_axis_tready = 1'b0;
        repeat (burst) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(res_t'(m_axis_tdata[83:0]), m_axis_tlast);
      n_results++;
    end
  end

  // Watchdog: cycles with no beat on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_count <= 0;
    else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
        $display("** cpu8bit_instruction_execute_core: FAILED **");
        $finish;
      end
    end
  end

  // Drive one instruction beat, holding until accepted.
  task automatic send_instr(instr_t i);
    s_axis_tdata = {1'b0, i};
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_instr(i);
    n_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  function automatic instr_t rand_instr();
    instr_t i;
    i = 111'({$urandom, $urandom, $urandom, $urandom});
    // mostly official mnemonics; now and then the illegal and unused codes
    i.kind = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(56, 63))
                                          : 6'($urandom_range(0, 55));
    // short branch offsets most of the time, so page crossings are a mix
    if ($urandom_range(0, 2) != 0) i.rel = {{8{i.rel[7]}}, i.rel[7:0]};
    if (i.kind == K_NOP && $urandom_range(0, 1) == 1)
      i.opc = {3'($urandom_range(0, 7)), 5'h1C};
    return i;
  endfunction

  function automatic instr_t mk(logic [5:0] k, logic [7:0] m);
    instr_t i;
    i = '0;
    i.kind = k; i.m = m;
    return i;
  endfunction

  initial begin
    instr_t i;
    sb = new();
    rst = 1'b1; quiet = 1'b0; n_sent = 0; n_results = 0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: extremes, carries and overflow, stack wrap, flag quirks.
    send_instr(mk(K_LDA, 8'h7F));
    send_instr(mk(K_ADC, 8'h01));          // signed overflow
    send_instr(mk(K_ADC, 8'hFF));          // carry out
    send_instr(mk(K_SBC, 8'hFF));
    send_instr(mk(K_CMP, 8'h00));
    i = mk(K_ROR, 8'h01); i.accm = 1'b1; send_instr(i);
    i = mk(K_ASL, 8'h80); i.ea = 16'hFFFF; send_instr(i);
    i = mk(K_BRK, 8'h00); i.pc = 16'hFFFF; i.vec = 16'h8000; send_instr(i);
    i = mk(K_RTI, 8'h00); i.p1 = 8'hFF; i.p2 = 8'h34; i.p3 = 8'h12; send_instr(i);
    i = mk(K_PLP, 8'h00); i.p1 = 8'hFF; send_instr(i);
    send_instr(mk(K_PHP, 8'h00));
    i = mk(K_BMI, 8'h00); i.pc = 16'h10F0; i.rel = 16'h0020; send_instr(i);
    i = mk(K_BEQ, 8'h00); i.pc = 16'h1000; i.rel = 16'hFFFE; send_instr(i);
    i = mk(K_JSR, 8'h00); i.pc = 16'h0000; i.ea = 16'hFFFF; send_instr(i);
    i = mk(K_RTS, 8'h00); i.p1 = 8'hFF; i.p2 = 8'hFF; send_instr(i);
    send_instr(mk(K_LDX, 8'h00));
    send_instr(mk(K_TXS, 8'h00));          // SP 0: next push wraps
    send_instr(mk(K_PHA, 8'h00));
    send_instr(mk(K_TSX, 8'h00));
    i = mk(K_NOP, 8'h00); i.opc = 8'hFC; send_instr(i);
    send_instr(mk(K_ILLEGAL, 8'h00));
    send_instr(mk(6'd63, 8'hFF));
    i = mk(K_STY, 8'h00); i.ea = 16'hFFFF; send_instr(i);
    send_instr(mk(K_BIT, 8'hC0));

    // Every mnemonic once, plus the illegal code 56, with random operands.
    for (int k = 0; k <= 56; k++) begin
      i = rand_instr(); i.kind = 6'(k); send_instr(i);
    end

    // Hold off until every pending result has drained.
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);

    for (int n = 0; n < 350; n++) begin
      if (n == 300) quiet = 1'b1;
      send_instr(rand_instr());
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("%0d instructions, all mnemonics plus illegal codes, %0d result beats",
             n_sent, n_results);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** cpu8bit_instruction_execute_core: PASSED **");
    else
      $display("** cpu8bit_instruction_execute_core: FAILED **");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/cpu8_pkg.sv
rtl/core/cpu8bit_instruction_execute_core.sv
dv/cpu8bit_instruction_execute_core_test.sv
